[rtl/fla_pkg.sv]
// ----------------------------------------------------------------------------
// fla_pkg: shared types and codes of the free-list heap allocator
// Holds request, policy and status codes and the control/status structs
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package fla_pkg;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_U_SCAN_RD,
        OP_FREE_PUSH,
        OP_U_INC,
        OP_SLOT_TAKE,
        OP_PICK_RD,
        OP_PICK_STEP,
        OP_BUMP,
        OP_TAKE_RD,
        OP_TAKE,
        OP_SHIFT_RD,
        OP_SHIFT_WR,
        OP_DROP_END,
        OP_SORT_INIT,
        OP_PASS_NEXT,
        OP_SRT_RDA,
        OP_SRT_RDB,
        OP_SRT_WRA,
        OP_SRT_WRB,
        OP_J_INC,
        OP_MERGE_INIT,
        OP_MRG_RD,
        OP_MRG_STEP,
        OP_MRG_END
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic umatch;     // used entry at scan index is valid and matches the address
        logic slot_free;  // used entry at scan index is free
        logic u_last;     // scan index is the last used entry
        logic free_full;  // free table holds its full depth
        logic fc_zero;    // free table empty
        logic scan_end;   // walk index reached the free count
        logic next_end;   // walk index plus one reaches the free count
        logic sort_done;  // all sort passes done
        logic found;      // search picked an entry that fits
        logic bump_fits;  // request fits in the untouched space
        logic compacted;  // this request already compacted the table
        logic swap;       // adjacent pair out of address order
    } dp_sts_t;

endpackage

[rtl/fla_ram.sv]
// ----------------------------------------------------------------------------
// fla_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fla_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/fla_ctrl.sv]
// ----------------------------------------------------------------------------
// fla_ctrl: allocator sequencer
// Steps a free through address scan and push, and an allocate through slot scan,
// fit search, bump, take/drop, sort and merge, one datapath command per cycle.
// ----------------------------------------------------------------------------
module fla_ctrl
    import fla_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       action,
    input  dp_sts_t    sts,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       done,
    output logic [1:0] status
);

    typedef enum logic [4:0] {
        S_IDLE, S_FSCAN, S_FCHK, S_ASLOT, S_PICK, S_PCMP, S_PDONE, S_TAKE,
        S_DROP, S_SHIFT, S_SORT, S_SRT_RDB, S_SRT_CMP, S_SRT_WRB, S_MRG,
        S_MRG_CHK, S_MRG_END
    } state_t;

    state_t     state_reg, state_next;
    logic       done_reg, done_next;
    logic [1:0] status_reg, status_next;

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        cmd.op      = OP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = (action == ACT_FREE) ? S_FSCAN : S_ASLOT;
                end
            end
            S_FSCAN:
            begin
                cmd.op     = OP_U_SCAN_RD;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (sts.umatch)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    if (sts.free_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.op      = OP_FREE_PUSH;
                        status_next = ST_OK;
                    end
                end
                else if (sts.u_last)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = ST_UNKNOWN;
                end
                else
                begin
                    cmd.op     = OP_U_INC;
                    state_next = S_FSCAN;
                end
            end
            S_ASLOT:
            begin
                if (sts.slot_free)
                begin
                    cmd.op     = OP_SLOT_TAKE;
                    state_next = S_PICK;
                end
                else if (sts.u_last)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.op = OP_U_INC;
                end
            end
            S_PICK:
            begin
                if (sts.scan_end)
                begin
                    state_next = S_PDONE;
                end
                else
                begin
                    cmd.op     = OP_PICK_RD;
                    state_next = S_PCMP;
                end
            end
            S_PCMP:
            begin
                cmd.op     = OP_PICK_STEP;
                state_next = S_PICK;
            end
            S_PDONE:
            begin
                if (sts.found)
                begin
                    cmd.op     = OP_TAKE_RD;
                    state_next = S_TAKE;
                end
                else if (sts.compacted || (!sts.bump_fits && sts.fc_zero))
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = ST_OOM;
                end
                else if (sts.bump_fits)
                begin
                    cmd.op      = OP_BUMP;
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = ST_OK;
                end
                else
                begin
                    cmd.op     = OP_SORT_INIT;
                    state_next = S_SORT;
                end
            end
            S_TAKE:
            begin
                cmd.op     = OP_TAKE;
                state_next = S_DROP;
            end
            S_DROP:
            begin
                if (sts.next_end)
                begin
                    cmd.op      = OP_DROP_END;
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = ST_OK;
                end
                else
                begin
                    cmd.op     = OP_SHIFT_RD;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.op     = OP_SHIFT_WR;
                state_next = S_DROP;
            end
            S_SORT:
            begin
                if (sts.sort_done)
                begin
                    cmd.op     = OP_MERGE_INIT;
                    state_next = S_MRG;
                end
                else if (sts.next_end)
                begin
                    cmd.op = OP_PASS_NEXT;
                end
                else
                begin
                    cmd.op     = OP_SRT_RDA;
                    state_next = S_SRT_RDB;
                end
            end
            S_SRT_RDB:
            begin
                cmd.op     = OP_SRT_RDB;
                state_next = S_SRT_CMP;
            end
            S_SRT_CMP:
            begin
                if (sts.swap)
                begin
                    cmd.op     = OP_SRT_WRA;
                    state_next = S_SRT_WRB;
                end
                else
                begin
                    cmd.op     = OP_J_INC;
                    state_next = S_SORT;
                end
            end
            S_SRT_WRB:
            begin
                cmd.op     = OP_SRT_WRB;
                state_next = S_SORT;
            end
            S_MRG:
            begin
                if (sts.scan_end)
                begin
                    state_next = S_MRG_END;
                end
                else
                begin
                    cmd.op     = OP_MRG_RD;
                    state_next = S_MRG_CHK;
                end
            end
            S_MRG_CHK:
            begin
                cmd.op     = OP_MRG_STEP;
                state_next = S_MRG;
            end
            S_MRG_END:
            begin
                cmd.op     = OP_MRG_END;
                state_next = S_PICK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe outside idle");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg || $past(start))
        else $error("result strobe held without a new transaction");
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

endmodule

[rtl/fla_dpath.sv]
// ----------------------------------------------------------------------------
// fla_dpath: allocator datapath
// Free and used tables in RAM, valid bits, counters, bump pointer and the
// fit, merge and absorb arithmetic, driven one command per cycle.
// ----------------------------------------------------------------------------
module fla_dpath
    import fla_pkg::*;
#(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 8,
    parameter int FREE_ENTRIES = 16,
    parameter int USED_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [15:0] request_bytes,
    input  logic [15:0] block_address,
    input  logic        fit_policy_we,
    input  logic [1:0]  fit_policy_wdata,
    output dp_sts_t     sts,
    output logic [15:0] payload_address
);

    localparam int FW = $clog2(FREE_ENTRIES);
    localparam int UW = $clog2(USED_ENTRIES);
    localparam logic [17:0] HDR  = 18'(HEADER_BYTES);
    localparam logic [17:0] HEAP = 18'(HEAP_BYTES);

    logic [1:0]    policy_reg;
    logic [15:0]   want_reg, addr_reg, payload_reg;
    logic [UW-1:0] u_reg, slot_reg;
    logic [FW:0]   fc_reg, i_reg, n_reg;
    logic [FW-1:0] pick_reg;
    logic          pick_ok_reg, compacted_reg;
    logic [15:0]   pick_size_reg;
    logic [16:0]   bump_reg;
    logic [15:0]   a_start_reg, a_size_reg, last_start_reg, last_size_reg;
    logic [USED_ENTRIES-1:0] valid_reg;

    // RAM ports
    logic          f_we, f_re, u_we, u_re;
    logic [FW-1:0] f_waddr, f_raddr;
    logic [15:0]   f_wstart, f_wsize, f_rstart, f_rsize;
    logic [UW-1:0] u_waddr;
    logic [15:0]   u_wstart, u_wsize, u_rstart, u_rsize;

    logic [FW:0]   i_inc, n_inc, n_dec;
    logic [16:0]   u_pay;
    logic [17:0]   last_end;
    logic          fits, take, adj;

    assign i_inc    = i_reg + 1'b1;
    assign n_inc    = n_reg + 1'b1;
    assign n_dec    = n_reg - 1'b1;
    assign u_pay    = {1'b0, u_rstart} + HDR[16:0];
    assign last_end = {2'b00, last_start_reg} + {2'b00, last_size_reg} + HDR;
    assign fits     = (f_rsize >= want_reg);
    assign adj      = (n_reg != '0) && (last_end == {2'b00, f_rstart});

    always_comb
    begin
        case (policy_reg)
            POL_BEST:  take = fits && (!pick_ok_reg || (f_rsize < pick_size_reg));
            POL_WORST: take = !pick_ok_reg || (f_rsize > pick_size_reg);
            default:   take = fits && !pick_ok_reg;
        endcase
    end

    // RAM addressing
    always_comb
    begin
        f_re     = 1'b0;
        f_raddr  = i_reg[FW-1:0];
        f_we     = 1'b0;
        f_waddr  = i_reg[FW-1:0];
        f_wstart = f_rstart;
        f_wsize  = f_rsize;
        u_re     = 1'b0;
        u_we     = 1'b0;
        u_waddr  = slot_reg;
        u_wstart = f_rstart;
        u_wsize  = f_rsize;
        case (cmd.op)
            OP_U_SCAN_RD: u_re = 1'b1;
            OP_FREE_PUSH:
            begin
                f_we     = 1'b1;
                f_waddr  = fc_reg[FW-1:0];
                f_wstart = u_rstart;
                f_wsize  = u_rsize;
            end
            OP_PICK_RD, OP_SRT_RDA, OP_MRG_RD: f_re = 1'b1;
            OP_TAKE_RD:
            begin
                f_re    = 1'b1;
                f_raddr = pick_reg;
            end
            OP_SHIFT_RD, OP_SRT_RDB:
            begin
                f_re    = 1'b1;
                f_raddr = i_inc[FW-1:0];
            end
            OP_SHIFT_WR, OP_SRT_WRA: f_we = 1'b1;
            OP_SRT_WRB:
            begin
                f_we     = 1'b1;
                f_waddr  = i_inc[FW-1:0];
                f_wstart = a_start_reg;
                f_wsize  = a_size_reg;
            end
            OP_MRG_STEP:
            begin
                f_we     = !adj && (n_reg != '0);
                f_waddr  = n_dec[FW-1:0];
                f_wstart = last_start_reg;
                f_wsize  = last_size_reg;
            end
            OP_MRG_END:
            begin
                f_we     = 1'b1;
                f_waddr  = n_dec[FW-1:0];
                f_wstart = last_start_reg;
                f_wsize  = (last_end == {1'b0, bump_reg})
                         ? 16'(18'(last_size_reg) + HEAP - {1'b0, bump_reg})
                         : last_size_reg;
            end
            OP_BUMP:
            begin
                u_we     = 1'b1;
                u_wstart = bump_reg[15:0];
                u_wsize  = want_reg;
            end
            OP_TAKE: u_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= POL_FIRST;
            fc_reg        <= '0;
            bump_reg      <= '0;
            valid_reg     <= '0;
            compacted_reg <= 1'b0;
            pick_ok_reg   <= 1'b0;
            u_reg         <= '0;
            i_reg         <= '0;
            n_reg         <= '0;
        end
        else
        begin
            if (fit_policy_we)
            begin
                policy_reg <= fit_policy_wdata;
            end
            case (cmd.op)
                OP_CAPTURE:
                begin
                    u_reg         <= '0;
                    compacted_reg <= 1'b0;
                end
                OP_FREE_PUSH:
                begin
                    fc_reg           <= fc_reg + 1'b1;
                    valid_reg[u_reg] <= 1'b0;
                end
                OP_U_INC: u_reg <= u_reg + 1'b1;
                OP_SLOT_TAKE, OP_SORT_INIT:
                begin
                    i_reg       <= '0;
                    n_reg       <= '0;
                    pick_ok_reg <= 1'b0;
                end
                OP_PICK_STEP:
                begin
                    i_reg <= i_inc;
                    if (take)
                    begin
                        pick_ok_reg <= 1'b1;
                    end
                end
                OP_BUMP:
                begin
                    bump_reg            <= 17'({1'b0, bump_reg} + {2'b00, want_reg} + HDR);
                    valid_reg[slot_reg] <= 1'b1;
                end
                OP_TAKE:
                begin
                    valid_reg[slot_reg] <= 1'b1;
                    i_reg               <= {1'b0, pick_reg};
                end
                OP_SHIFT_WR, OP_J_INC, OP_SRT_WRB: i_reg <= i_inc;
                OP_DROP_END: fc_reg <= fc_reg - 1'b1;
                OP_PASS_NEXT:
                begin
                    n_reg <= n_inc;
                    i_reg <= '0;
                end
                OP_MERGE_INIT:
                begin
                    n_reg <= '0;
                    i_reg <= '0;
                end
                OP_MRG_STEP:
                begin
                    i_reg <= i_inc;
                    if (!adj)
                    begin
                        n_reg <= n_inc;
                    end
                end
                OP_MRG_END:
                begin
                    fc_reg        <= n_reg;
                    compacted_reg <= 1'b1;
                    i_reg         <= '0;
                    pick_ok_reg   <= 1'b0;
                    if (last_end == {1'b0, bump_reg})
                    begin
                        bump_reg <= HEAP[16:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                want_reg    <= request_bytes;
                addr_reg    <= block_address;
                payload_reg <= '0;
            end
            OP_SLOT_TAKE: slot_reg <= u_reg;
            OP_PICK_STEP:
            begin
                if (take)
                begin
                    pick_reg      <= i_reg[FW-1:0];
                    pick_size_reg <= f_rsize;
                end
            end
            OP_BUMP: payload_reg <= 16'({1'b0, bump_reg} + HDR);
            OP_TAKE: payload_reg <= 16'({2'b00, f_rstart} + HDR);
            OP_SRT_RDB:
            begin
                a_start_reg <= f_rstart;
                a_size_reg  <= f_rsize;
            end
            OP_MRG_STEP:
            begin
                if (adj)
                begin
                    last_size_reg <= 16'(18'(last_size_reg) + 18'(f_rsize) + HDR);
                end
                else
                begin
                    last_start_reg <= f_rstart;
                    last_size_reg  <= f_rsize;
                end
            end
            default: ;
        endcase
    end

    fla_ram #(.WIDTH(16), .DEPTH(FREE_ENTRIES)) u_free_start (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wstart),
        .re(f_re), .raddr(f_raddr), .rdata(f_rstart));
    fla_ram #(.WIDTH(16), .DEPTH(FREE_ENTRIES)) u_free_size (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wsize),
        .re(f_re), .raddr(f_raddr), .rdata(f_rsize));
    fla_ram #(.WIDTH(16), .DEPTH(USED_ENTRIES)) u_used_start (
        .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wstart),
        .re(u_re), .raddr(u_reg), .rdata(u_rstart));
    fla_ram #(.WIDTH(16), .DEPTH(USED_ENTRIES)) u_used_size (
        .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wsize),
        .re(u_re), .raddr(u_reg), .rdata(u_rsize));

    always_comb
    begin
        sts.umatch    = valid_reg[u_reg] && (u_pay[15:0] == addr_reg);
        sts.slot_free = !valid_reg[u_reg];
        sts.u_last    = (u_reg == UW'(USED_ENTRIES - 1));
        sts.free_full = (fc_reg >= (FW + 1)'(FREE_ENTRIES));
        sts.fc_zero   = (fc_reg == '0);
        sts.scan_end  = (i_reg == fc_reg);
        sts.next_end  = (i_inc >= fc_reg);
        sts.sort_done = (n_inc >= fc_reg);
        sts.found     = pick_ok_reg && (pick_size_reg >= want_reg);
        sts.bump_fits = ((HEAP - {1'b0, bump_reg}) >= ({2'b00, want_reg} + HDR));
        sts.compacted = compacted_reg;
        sts.swap      = (a_start_reg > f_rstart);
    end

    assign payload_address = payload_reg;

    a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= (FW + 1)'(FREE_ENTRIES))
        else $error("free count past table depth");
    a_bump_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, bump_reg} <= HEAP)
        else $error("bump pointer past heap end");
    a_slot_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.op == OP_BUMP) || (cmd.op == OP_TAKE)) |-> !valid_reg[slot_reg])
        else $error("grant into a used slot");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FREE_PUSH) |-> (!sts.free_full && sts.umatch))
        else $error("free push without room or match");

endmodule

[rtl/free_list_heap_allocator.sv]
// ----------------------------------------------------------------------------
// free_list_heap_allocator: header-prefixed heap allocator with fit policy
// Controller and datapath around free and used block tables in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with action, request_bytes and block_address; the transaction
//   is taken at a clock edge where start is high and busy is low. busy then
//   stays high until the result. The result shows for exactly one cycle with
//   done high, carrying payload_address (zero unless an allocate granted a
//   block) and status. The receiver cannot stall; capture on done.
//   fit_policy_we/fit_policy_wdata write the fit policy; write only when idle.
// Sequence, from the accepting edge to the rise of done:
//   free: scan the used entries in order for a match; an unknown address
//   scans them all. allocate: scan for a free used slot, then a fit search
//   over the free entries; a bump grant ends there, taking entry p shifts
//   the entries above it down. Compaction adds a bubble sort and a merge,
//   then a second search.
// Throughput: one transaction at a time; busy drops in the done cycle, so
//   the next one can be taken at the edge that ends it.
// Reset: tables empty, bump pointer at heap start, first fit; no clearing
//   pass is needed since only entries below the free count or marked valid
//   are ever used.
// ----------------------------------------------------------------------------
module free_list_heap_allocator
    import fla_pkg::*;
#(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 8,
    parameter int FREE_ENTRIES = 16,
    parameter int USED_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        action,
    input  logic [15:0] request_bytes,
    input  logic [15:0] block_address,
    input  logic        fit_policy_we,
    input  logic [1:0]  fit_policy_wdata,
    output logic        busy,
    output logic        done,
    output logic [15:0] payload_address,
    output logic [1:0]  status
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer: one datapath command per cycle
    fla_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .status (status)
    );

    // tables, pointers and arithmetic
    fla_dpath #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .FREE_ENTRIES (FREE_ENTRIES),
        .USED_ENTRIES (USED_ENTRIES)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .request_bytes    (request_bytes),
        .block_address    (block_address),
        .fit_policy_we    (fit_policy_we),
        .fit_policy_wdata (fit_policy_wdata),
        .sts              (sts),
        .payload_address  (payload_address)
    );

endmodule
